### rtl/sxtok_pkg.sv
// ----------------------------------------------------------------------------
// sxtok_pkg
// Shared types, constants and character classes of the token scanner.
// ----------------------------------------------------------------------------
package sxtok_pkg;

  localparam int unsigned MaxLenDigits = 9;
  localparam int unsigned QDepth       = 8;
  localparam int unsigned QAw          = $clog2(QDepth);
  localparam int unsigned MaxRecs      = 3;

  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChQuote   = 8'h22;
  localparam logic [7:0] ChLParen  = 8'h28;
  localparam logic [7:0] ChRParen  = 8'h29;
  localparam logic [7:0] ChStar    = 8'h2A;
  localparam logic [7:0] ChSlash   = 8'h2F;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChColon   = 8'h3A;
  localparam logic [7:0] ChSemi    = 8'h3B;
  localparam logic [7:0] ChBslash  = 8'h5C;

  typedef enum logic [2:0] {
    KLbr     = 3'd0,
    KRbr     = 3'd1,
    KQuoted  = 3'd2,
    KData    = 3'd3,
    KSymbol  = 3'd4,
    KInvalid = 3'd5,
    KEof     = 3'd6
  } kind_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       has_byte;
    logic       end_of_text;
  } item_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] start;
    logic [31:0] length;
    logic        fin;
  } rec_t;

  function automatic logic is_dig(logic [7:0] c);
    return (c inside {[8'h30:8'h39]});
  endfunction

  function automatic logic is_vis(logic [7:0] c);
    return (c inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39],
                      8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h5F, 8'h3D, 8'h3F,
                      8'h24, 8'h25, 8'h26, 8'h23, 8'h7E, 8'h3C, 8'h3E,
                      8'h2E, 8'h27, 8'h3A, 8'h5E, 8'h7C, 8'h40});
  endfunction

endpackage

### rtl/sxtok_scan.sv
// ----------------------------------------------------------------------------
// sxtok_scan
// Scanner state and the single-pass next-state and record logic per item.
// ----------------------------------------------------------------------------
module sxtok_scan (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  step_i,
  input  sxtok_pkg::item_t                      item_i,
  output sxtok_pkg::rec_t [sxtok_pkg::MaxRecs-1:0] recs_o,
  output logic [1:0]                            rec_cnt_o
);

  typedef enum logic [3:0] {
    MIdle   = 4'd0,
    MSlash  = 4'd1,
    MSemi   = 4'd2,
    MLine   = 4'd3,
    MBlock  = 4'd4,
    MBstar  = 4'd5,
    MQuoted = 4'd6,
    MDigits = 4'd7,
    MData   = 4'd8,
    MSymbol = 4'd9
  } mode_e;

  mode_e       mode_q, mode_d;
  logic [31:0] pos_q, pos_d;
  logic [31:0] tbeg_q, tbeg_d;
  logic [3:0]  dcnt_q, dcnt_d;
  logic [29:0] drem_q, drem_d;
  logic        esc_q, esc_d;
  logic        lz_q, lz_d;

  sxtok_pkg::rec_t [sxtok_pkg::MaxRecs-1:0] recs;
  logic [1:0]                                 n;

  always_comb begin
    logic [7:0]  c;
    logic [31:0] p;
    logic [31:0] pay;
    logic        start_now;
    logic        sym_path;
    mode_e       m;
    logic [31:0] tb;
    logic [3:0]  dc;
    logic [29:0] dr;
    logic        es;
    logic        lz;

    c         = item_i.text_byte;
    p         = pos_q;
    pay       = '0;
    start_now = 1'b0;
    sym_path  = 1'b0;
    m         = mode_q;
    tb        = tbeg_q;
    dc        = dcnt_q;
    dr        = drem_q;
    es        = esc_q;
    lz        = lz_q;
    n         = 2'd0;
    recs      = '0;
    pos_d     = pos_q;

    if (item_i.has_byte) begin
      pos_d = pos_q + 32'd1;
      case (m)
        MSlash: begin
          if (c == sxtok_pkg::ChSlash) begin
            m = MLine;
          end else if (c == sxtok_pkg::ChStar) begin
            m = MBlock;
          end else begin
            sym_path = 1'b1;
          end
        end
        MSemi: begin
          if (c == sxtok_pkg::ChSemi) begin
            m = MLine;
          end else begin
            recs[n] = '{sxtok_pkg::KInvalid, tb, 32'd1, 1'b0};
            n = n + 2'd1;
            start_now = 1'b1;
          end
        end
        MLine: begin
          if (c == sxtok_pkg::ChNewline) m = MIdle;
        end
        MBlock: begin
          if (c == sxtok_pkg::ChStar) m = MBstar;
        end
        MBstar: begin
          if (c == sxtok_pkg::ChSlash) begin
            m = MIdle;
          end else if (c != sxtok_pkg::ChStar) begin
            m = MBlock;
          end
        end
        MQuoted: begin
          if (es) begin
            es = 1'b0;
          end else if (c == sxtok_pkg::ChBslash) begin
            es = 1'b1;
          end else if (c == sxtok_pkg::ChQuote) begin
            recs[n] = '{sxtok_pkg::KQuoted, tb, p - tb, 1'b0};
            n = n + 2'd1;
            m = MIdle;
          end
        end
        MDigits: begin
          if (sxtok_pkg::is_dig(c)) begin
            if (dc <= 4'(sxtok_pkg::MaxLenDigits)) dc = dc + 4'd1;
            if (dc <= 4'(sxtok_pkg::MaxLenDigits)) begin
              dr = (dr << 3) + (dr << 1) + 30'(c - sxtok_pkg::ChZero);
            end
          end else if (c == sxtok_pkg::ChColon) begin
            if (dc > 4'(sxtok_pkg::MaxLenDigits) || lz) begin
              recs[n] = '{sxtok_pkg::KInvalid, tb, p - tb, 1'b0};
              n = n + 2'd1;
              m = MIdle;
            end else begin
              m = MData;
            end
          end else begin
            sym_path = 1'b1;
          end
        end
        MData: begin
          dr = dr - 30'd1;
          if (dr == '0) begin
            pay = tb + 32'(dc) + 32'd1;
            recs[n] = '{sxtok_pkg::KData, pay, p + 32'd1 - pay, 1'b0};
            n = n + 2'd1;
            m = MIdle;
          end
        end
        MSymbol: sym_path = 1'b1;
        default: start_now = 1'b1;
      endcase

      if (sym_path) begin
        if (sxtok_pkg::is_vis(c)) begin
          m = MSymbol;
        end else begin
          recs[n] = '{sxtok_pkg::KSymbol, tb, p - tb, 1'b0};
          n = n + 2'd1;
          start_now = 1'b1;
        end
      end

      if (start_now) begin
        m  = MIdle;
        tb = p;
        if (c == sxtok_pkg::ChSpace || c == sxtok_pkg::ChNewline) begin
          m = MIdle;
        end else if (c == sxtok_pkg::ChSlash) begin
          m = MSlash;
        end else if (c == sxtok_pkg::ChSemi) begin
          m = MSemi;
        end else if (c == sxtok_pkg::ChLParen) begin
          recs[n] = '{sxtok_pkg::KLbr, p, 32'd1, 1'b0};
          n = n + 2'd1;
        end else if (c == sxtok_pkg::ChRParen) begin
          recs[n] = '{sxtok_pkg::KRbr, p, 32'd1, 1'b0};
          n = n + 2'd1;
        end else if (c == sxtok_pkg::ChQuote) begin
          m  = MQuoted;
          tb = p + 32'd1;
          es = 1'b0;
        end else if (sxtok_pkg::is_dig(c)) begin
          m  = MDigits;
          dc = 4'd1;
          lz = (c == sxtok_pkg::ChZero);
          dr = 30'(c - sxtok_pkg::ChZero);
        end else if (c != sxtok_pkg::ChColon && sxtok_pkg::is_vis(c)) begin
          m = MSymbol;
        end else begin
          recs[n] = '{sxtok_pkg::KInvalid, p, 32'd1, 1'b0};
          n = n + 2'd1;
        end
      end
    end

    if (item_i.end_of_text) begin
      case (m)
        MSlash: begin
          recs[n] = '{sxtok_pkg::KSymbol, tb, 32'd1, 1'b0};
          n = n + 2'd1;
        end
        MSemi: begin
          recs[n] = '{sxtok_pkg::KInvalid, tb, 32'd1, 1'b0};
          n = n + 2'd1;
        end
        MSymbol: begin
          recs[n] = '{sxtok_pkg::KSymbol, tb, pos_d - tb, 1'b0};
          n = n + 2'd1;
        end
        MBlock, MBstar: begin
          recs[n] = '{sxtok_pkg::KInvalid, tb, pos_d - tb, 1'b0};
          n = n + 2'd1;
        end
        MData: begin
          recs[n] = '{sxtok_pkg::KInvalid, tb, 32'(dc), 1'b0};
          n = n + 2'd1;
        end
        default: ;
      endcase
      recs[n] = '{sxtok_pkg::KEof, pos_d, 32'd0, 1'b1};
      n = n + 2'd1;
      m     = MIdle;
      pos_d = '0;
      tb    = '0;
      dc    = '0;
      dr    = '0;
      es    = 1'b0;
      lz    = 1'b0;
    end

    mode_d = m;
    tbeg_d = tb;
    dcnt_d = dc;
    drem_d = dr;
    esc_d  = es;
    lz_d   = lz;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MIdle;
      pos_q  <= '0;
      tbeg_q <= '0;
      dcnt_q <= '0;
      drem_q <= '0;
      esc_q  <= 1'b0;
      lz_q   <= 1'b0;
    end else if (step_i) begin
      mode_q <= mode_d;
      pos_q  <= pos_d;
      tbeg_q <= tbeg_d;
      dcnt_q <= dcnt_d;
      drem_q <= drem_d;
      esc_q  <= esc_d;
      lz_q   <= lz_d;
    end
  end

  assign recs_o    = recs;
  assign rec_cnt_o = step_i ? n : 2'd0;

endmodule

### rtl/sxtok_rq.sv
// ----------------------------------------------------------------------------
// sxtok_rq
// Result queue taking up to three records per cycle and giving one.
// ----------------------------------------------------------------------------
module sxtok_rq (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  sxtok_pkg::rec_t [sxtok_pkg::MaxRecs-1:0] recs_i,
  input  logic [1:0]                            push_cnt_i,
  input  logic                                  pop_i,
  output logic                                  room_o,
  output logic                                  valid_o,
  output sxtok_pkg::rec_t                       head_o
);

  localparam int unsigned CntW = sxtok_pkg::QAw + 1;

  sxtok_pkg::rec_t [sxtok_pkg::QDepth-1:0] mem_q;
  logic [sxtok_pkg::QAw-1:0]               wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]                          cnt_q, cnt_d;
  logic                                     pop;

  assign pop     = pop_i && (cnt_q != '0);
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign room_o  = (cnt_q <= CntW'(sxtok_pkg::QDepth - sxtok_pkg::MaxRecs));
  assign cnt_d   = cnt_q + CntW'(push_cnt_i) - CntW'(pop);

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < sxtok_pkg::MaxRecs; i++) begin
      if (2'(i) < push_cnt_i) begin
        mem_q[wr_ptr_q + sxtok_pkg::QAw'(i)] <= recs_i[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + sxtok_pkg::QAw'(push_cnt_i);
      if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

endmodule

### rtl/sexpr_token_scanner.sv
// ----------------------------------------------------------------------------
// sexpr_token_scanner
// Streaming tokenizer for canonical S-expression text, up to one byte per cycle.
// ----------------------------------------------------------------------------
// The slave channel carries one text byte per transaction, with tuser set
// when the byte is present and tlast on the final transaction of a text.
// The master channel carries one token record per transaction: the kind in
// tuser, start offset and length in tdata, and tlast on the eof record.
// An input transaction is held in an input register and scanned once the
// result queue has room; the records it causes (up to three) enter an
// eight-entry result queue and appear on the master side in the cycle
// after they are written.
// One input transaction is accepted per cycle as long as the queue has room
// for three records; the output drains one record per ready cycle, so sustained
// throughput is one byte per cycle whenever bytes cause one record or fewer.
// When the receiver stalls, records wait in the queue and the input side
// stops once the queue cannot take another three.
// Reset empties the queue and the input register and returns the scanner
// to offset zero between tokens; after each eof the scanner alone returns
// there, while records already queued still drain in order.
// ----------------------------------------------------------------------------
module sexpr_token_scanner (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic        s_axis_tuser,   // has_byte
  input  logic        s_axis_tlast,   // end_of_text
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [31:0] token_start, [63:32] token_length
  output logic [2:0]  m_axis_tuser,   // token_kind
  output logic        m_axis_tlast    // final_token
);

  logic                                     in_valid_q;
  sxtok_pkg::item_t                         in_item_q;
  logic                                     step;
  logic                                     room;
  logic                                     load;
  sxtok_pkg::rec_t [sxtok_pkg::MaxRecs-1:0] recs;
  logic [1:0]                               rec_cnt;
  sxtok_pkg::rec_t                          head;

  assign step          = in_valid_q && room;
  assign s_axis_tready = !in_valid_q || step;
  assign load          = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (load) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      in_item_q <= '{s_axis_tdata, s_axis_tuser, s_axis_tlast};
    end
  end

  sxtok_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .item_i    (in_item_q),
    .recs_o    (recs),
    .rec_cnt_o (rec_cnt)
  );

  sxtok_rq u_rq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .recs_i     (recs),
    .push_cnt_i (rec_cnt),
    .pop_i      (m_axis_tready),
    .room_o     (room),
    .valid_o    (m_axis_tvalid),
    .head_o     (head)
  );

  assign m_axis_tdata = {head.length, head.start};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.fin;

endmodule

### rtl/sxtok_chk.sv
// ----------------------------------------------------------------------------
// sxtok_chk
// Port-level checks of the token scanner, bound to the top level.
// ----------------------------------------------------------------------------
module sxtok_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled record changed");

  a_last_eof: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == sxtok_pkg::KEof)
    else $error("tlast on a record that is not eof");

  a_eof_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == sxtok_pkg::KEof |->
      m_axis_tlast && m_axis_tdata[63:32] == 32'd0)
    else $error("eof record malformed");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser != 3'd7)
    else $error("undefined token kind");

endmodule

bind sexpr_token_scanner sxtok_chk u_sxtok_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
